>>> sv/fss_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the fuzzy subsequence scorer.
// No dependencies; imported by every module of the block except fss_ram.
package fss_pkg;

    localparam int DEF_MAX_TARGET = 256;
    localparam int DEF_CHAR_BITS  = 16;

    localparam int CODE_W    = 16;   // char_code field width
    localparam int OP_W      = 2;
    localparam int SCORE_W   = 15;
    localparam int REG_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int RUN_W     = 16;   // running score, two's complement

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_FINISH = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] REG_CONSEC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

    localparam logic [REG_W-1:0] RST_CONSEC   = 6'd10;
    localparam logic [REG_W-1:0] RST_BOUNDARY = 6'd15;
    localparam logic [REG_W-1:0] RST_GAP      = 6'd1;

    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COMPARE,
        ST_ACCUM
    } t_state;

    typedef struct packed {
        logic clear;      // drop target, restart query
        logic append;     // store char at end of target
        logic query;      // latch query char, mark query seen
        logic finish;     // load result, restart query
        logic scan_fail;  // scan ran off the end of the target
        logic step;       // no match at scan position, advance
        logic hit;        // match at scan position, register delta
        logic accum;      // add delta, move past the match
    } t_cmd;

    typedef struct packed {
        logic out_busy;   // result register full and not drained this cycle
        logic failed;
        logic scan_end;
        logic char_hit;
    } t_status;

endpackage

>>> sv/fuzzy_subsequence_scorer.sv
`timescale 1ns / 1ps
// Fuzzy subsequence scorer, top level: stream ports, config port, controller and datapath.
// Depends on fss_pkg, fss_ctrl, fss_datapath (and fss_ram below it).
//
// Load a target with append items (op 1) after a clear (op 0), then send query
// characters (op 2) and a finish (op 3); the finish returns one result holding
// the score and the overflow flag. A query character scans forward from the last match
// through the target memory; each target character examined is read, then compared, as
// set by the registered read port of the target RAM, and a match is then accumulated.
// Once the query has failed, a query character is taken without a scan. Across one
// query the scan never moves back. The result register frees the input side: a new
// item is taken while a result waits, except a finish while that result is stalled.
// Config writes are always taken; write only while the block is idle.
module fuzzy_subsequence_scorer import fss_pkg::*; #(
    parameter int MAX_TARGET = DEF_MAX_TARGET,
    parameter int CHAR_BITS  = DEF_CHAR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CODE_W-1:0]    s_axis_tdata,   // [15:0] char_code
    input  logic [OP_W-1:0]      s_axis_tuser,   // [1:0] op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,   // [14:0] score, [15] zero
    output logic [0:0]           m_axis_tuser,   // [0] target_overflow
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data
);

    t_cmd               w_cmd;
    t_status            w_status;
    logic [SCORE_W-1:0] w_score;
    logic               w_ovf;

    assign o_cfg_ready = 1'b1;

    fss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (t_op'(s_axis_tuser)),
        .o_ready (s_axis_tready),
        .i_status(w_status),
        .o_cmd   (w_cmd)
    );

    fss_datapath #(
        .MAX_TARGET(MAX_TARGET),
        .CHAR_BITS (CHAR_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_char     (s_axis_tdata),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_score    (w_score),
        .o_overflow (w_ovf)
    );

    assign m_axis_tdata = {1'b0, w_score};
    assign m_axis_tuser = w_ovf;

endmodule

>>> sv/fss_ram.sv
`timescale 1ns / 1ps
// Simple dual-port RAM, one write and one registered read port.
// No dependencies.
module fss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fss_datapath.sv
`timescale 1ns / 1ps
// Datapath: target memory, scan pointer, score accumulator, config and result register.
// Depends on fss_pkg and fss_ram; driven by commands from fss_ctrl.
module fss_datapath import fss_pkg::*; #(
    parameter int MAX_TARGET = DEF_MAX_TARGET,
    parameter int CHAR_BITS  = DEF_CHAR_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [CODE_W-1:0]    i_char,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [SCORE_W-1:0]   o_score,
    output logic                 o_overflow
);

    localparam int CW = (CHAR_BITS < CODE_W) ? CHAR_BITS : CODE_W;
    localparam int AW = $clog2(MAX_TARGET);
    localparam int PW = $clog2(MAX_TARGET + 1);
    localparam int MW = REG_W + PW;
    localparam int DW = MW + 2;
    localparam int SW = ((DW > RUN_W) ? DW : RUN_W) + 1;
    localparam logic signed [SW-1:0] SUM_HI = SW'((2 ** (RUN_W - 1)) - 1);
    localparam logic signed [SW-1:0] SUM_LO = -SUM_HI - SW'(1);

    function automatic logic is_upper(input logic [CW-1:0] c);
        return (c >= CW'(UPPER_A)) && (c <= CW'(UPPER_Z));
    endfunction

    logic [PW-1:0]           r_len, r_pos, r_pmatch;
    logic                    r_pvalid, r_failed, r_ovf, r_qseen;
    logic signed [RUN_W-1:0] r_run;
    logic signed [DW-1:0]    r_delta;
    logic [CW-1:0]           r_qchar, r_prev_char;
    logic [REG_W-1:0]        r_consec, r_bound, r_gap;
    logic                    r_out_valid, r_out_ovf;
    logic [SCORE_W-1:0]      r_out_score;

    logic [CW-1:0]        w_rd_data;
    logic                 w_full, w_boundary, w_adjacent;
    logic [PW-1:0]        w_gap_cnt;
    logic [MW-1:0]        w_gap_prod;
    logic signed [DW-1:0] w_delta;
    logic signed [SW-1:0] w_sum, w_sat;
    logic [SCORE_W-1:0]   w_final;

    assign w_full = (r_len == PW'(MAX_TARGET));

    fss_ram #(
        .WIDTH(CW),
        .DEPTH(MAX_TARGET)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.append && !w_full),
        .i_waddr(r_len[AW-1:0]),
        .i_wdata(i_char[CW-1:0]),
        .i_raddr(r_pos[AW-1:0]),
        .o_rdata(w_rd_data)
    );

    // r_prev_char holds the target char just before the scan position
    always_comb begin
        w_boundary = (r_pos == '0) || (r_prev_char == CW'(SPACE_CHAR)) ||
                     (is_upper(w_rd_data) && !is_upper(r_prev_char));
        w_adjacent = (r_pos == r_pmatch + PW'(1));
        w_gap_cnt  = r_pos - r_pmatch - PW'(1);
        w_gap_prod = MW'(r_gap) * MW'(w_gap_cnt);
        w_delta    = DW'(1);
        if (w_boundary) begin
            w_delta = w_delta + DW'(r_bound);
        end
        if (r_pvalid) begin
            if (w_adjacent) begin
                w_delta = w_delta + DW'(r_consec);
            end else begin
                w_delta = w_delta - $signed({2'b00, w_gap_prod});
            end
        end
    end

    always_comb begin
        w_sum = SW'(r_run) + SW'(r_delta);
        if (w_sum > SUM_HI) begin
            w_sat = SUM_HI;
        end else if (w_sum < SUM_LO) begin
            w_sat = SUM_LO;
        end else begin
            w_sat = w_sum;
        end
    end

    always_comb begin
        if (!r_qseen) begin
            w_final = SCORE_W'(1);
        end else if (r_failed) begin
            w_final = '0;
        end else if (r_run < RUN_W'(1)) begin
            w_final = SCORE_W'(1);
        end else begin
            w_final = r_run[SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_pos       <= '0;
            r_pmatch    <= '0;
            r_pvalid    <= 1'b0;
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_qseen     <= 1'b0;
            r_run       <= '0;
            r_consec    <= RST_CONSEC;
            r_bound     <= RST_BOUNDARY;
            r_gap       <= RST_GAP;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CONSEC:   r_consec <= i_cfg_data;
                    REG_BOUNDARY: r_bound  <= i_cfg_data;
                    REG_GAP:      r_gap    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.clear || i_cmd.finish) begin
                r_pos    <= '0;
                r_pmatch <= '0;
                r_pvalid <= 1'b0;
                r_run    <= '0;
                r_failed <= 1'b0;
                r_qseen  <= 1'b0;
            end
            if (i_cmd.clear) begin
                r_len <= '0;
                r_ovf <= 1'b0;
            end
            if (i_cmd.append) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_len <= r_len + PW'(1);
                end
            end
            if (i_cmd.query) begin
                r_qseen <= 1'b1;
            end
            if (i_cmd.scan_fail) begin
                r_failed <= 1'b1;
            end
            if (i_cmd.step) begin
                r_pos <= r_pos + PW'(1);
            end
            if (i_cmd.accum) begin
                r_run    <= RUN_W'(w_sat);
                r_pmatch <= r_pos;
                r_pvalid <= 1'b1;
                r_pos    <= r_pos + PW'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_qchar <= i_char[CW-1:0];
        end
        if (i_cmd.step) begin
            r_prev_char <= w_rd_data;
        end
        if (i_cmd.accum) begin
            r_prev_char <= r_qchar;
        end
        if (i_cmd.hit) begin
            r_delta <= w_delta;
        end
        if (i_cmd.finish) begin
            r_out_score <= w_final;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_status.failed   = r_failed;
    assign o_status.scan_end = (r_pos >= r_len);
    assign o_status.char_hit = (w_rd_data == r_qchar);

    assign o_out_valid = r_out_valid;
    assign o_score     = r_out_score;
    assign o_overflow  = r_out_ovf;

endmodule

>>> sv/fss_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: input handshake and the sequencing of the target scan.
// Depends on fss_pkg; issues commands to fss_datapath.
module fss_ctrl import fss_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_op     i_op,
    output logic    o_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   w_accept;

    assign o_ready  = (r_state == ST_IDLE) && !((i_op == OP_FINISH) && i_status.out_busy);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_op == OP_QUERY) && !i_status.failed) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = i_status.scan_end ? ST_IDLE : ST_COMPARE;
            end
            ST_COMPARE: begin
                n_state = i_status.char_hit ? ST_ACCUM : ST_READ;
            end
            ST_ACCUM: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.clear  = w_accept && (i_op == OP_CLEAR);
                o_cmd.append = w_accept && (i_op == OP_APPEND);
                o_cmd.query  = w_accept && (i_op == OP_QUERY);
                o_cmd.finish = w_accept && (i_op == OP_FINISH);
            end
            ST_READ: begin
                o_cmd.scan_fail = i_status.scan_end;
            end
            ST_COMPARE: begin
                o_cmd.hit  = i_status.char_hit;
                o_cmd.step = !i_status.char_hit;
            end
            ST_ACCUM: begin
                o_cmd.accum = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

>>> sv/fss_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the fuzzy subsequence scorer, bound to the top level.
// Depends on fss_pkg.
module fss_checker import fss_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [OP_W-1:0]      s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [15:0]          m_axis_tdata,
    input logic [0:0]           m_axis_tuser
);

    logic w_in_xfer, w_fin_xfer, w_clr_xfer;

    assign w_in_xfer  = i_rst_n && s_axis_tvalid && s_axis_tready;
    assign w_fin_xfer = w_in_xfer && (s_axis_tuser == OP_FINISH);
    assign w_clr_xfer = w_in_xfer && (s_axis_tuser == OP_CLEAR);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // each finish transfer presents a result on the next cycle
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_xfer |=> m_axis_tvalid)
        else $error("finish without result");

    // results appear only after a finish transfer
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_fin_xfer))
        else $error("result without finish");

    // clear then finish: empty query scores 1, no overflow
    a_empty_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_xfer ##1 w_fin_xfer |=> (m_axis_tdata == 16'd1) && (m_axis_tuser == 1'b0))
        else $error("empty query score wrong");

endmodule

bind fuzzy_subsequence_scorer fss_checker u_fss_checker (.*);
